### src/tsvd_pkg.sv
// Shared constants, codes and types of the truncated SVD solver.
`default_nettype none
package tsvd_pkg;

    // Sizes of the stores and of the fixed-point values.
    localparam int MAX_DIM   = 16;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int CNT_W     = DIM_W + 1;
    localparam int ADDR_W    = 2 * DIM_W;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + CNT_W;
    localparam int DIV_N_W   = DATA_W + FRAC_BITS + 1;
    localparam int DIV_C_W   = $clog2(DIV_N_W + 1);
    localparam int FUNC_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 5;

    // Input function codes.
    localparam logic [FUNC_W-1:0] FN_LOAD_U   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_S   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_LOAD_VT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_LOAD_RHS = 3'd3;
    localparam logic [FUNC_W-1:0] FN_START    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_U    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_VT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_USED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd3;

    // Read request to the operand stores.
    typedef struct packed {
        logic [ADDR_W-1:0] mat_addr;
        logic [DIM_W-1:0]  vec_addr;
        logic [DIM_W-1:0]  sv_addr;
        logic              use_u;
        logic              use_coeff;
    } t_rd_req;

    // Status of the multiply-accumulate unit.
    typedef struct packed {
        logic              busy;
        logic              sat;
        logic [DATA_W-1:0] res;
    } t_mac_sts;

    // Result of the divider.
    typedef struct packed {
        logic              done;
        logic              err;
        logic [DATA_W-1:0] quo;
    } t_div_res;

    // Clamp a dimension register to 1..MAX_DIM.
    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (CNT_W'(v) > CNT_W'(MAX_DIM)) begin
            r = CNT_W'(MAX_DIM);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    // Clamp the rank register to at most MAX_DIM.
    function automatic logic [CNT_W-1:0] clamp_rank(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (CNT_W'(v) > CNT_W'(MAX_DIM)) begin
            r = CNT_W'(MAX_DIM);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### src/tsvd_store.sv
// Operand stores: U, Vt, singular values, right-hand vector and coefficients.
`default_nettype none
module tsvd_store import tsvd_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_ld_we,
    input  wire logic [FUNC_W-1:0]        i_ld_func,
    input  wire logic [DIM_W-1:0]         i_ld_row,
    input  wire logic [DIM_W-1:0]         i_ld_col,
    input  wire logic [DATA_W-1:0]        i_ld_value,
    input  wire logic                     i_cf_we,
    input  wire logic [DIM_W-1:0]         i_cf_addr,
    input  wire logic [DATA_W-1:0]        i_cf_data,
    input  wire t_rd_req                  i_rd,
    output logic [DATA_W-1:0]             o_mat,
    output logic [DATA_W-1:0]             o_vec,
    output logic [DATA_W-1:0]             o_sv
);

    logic [DATA_W-1:0] r_u   [MAX_DIM*MAX_DIM];
    logic [DATA_W-1:0] r_vt  [MAX_DIM*MAX_DIM];
    logic [DATA_W-1:0] r_sv  [MAX_DIM];
    logic [DATA_W-1:0] r_rhs [MAX_DIM];
    logic [DATA_W-1:0] r_cf  [MAX_DIM];

    logic [DATA_W-1:0] r_u_q;
    logic [DATA_W-1:0] r_vt_q;
    logic [DATA_W-1:0] r_rhs_q;
    logic [DATA_W-1:0] r_cf_q;
    logic [DATA_W-1:0] r_sv_q;
    logic              r_sel_u;
    logic              r_sel_cf;

    // Left factor memory.
    always_ff @(posedge i_clk) begin
        if (i_ld_we && i_ld_func == FN_LOAD_U) begin
            r_u[{i_ld_row, i_ld_col}] <= i_ld_value;
        end
        r_u_q <= r_u[i_rd.mat_addr];
    end

    // Right factor memory.
    always_ff @(posedge i_clk) begin
        if (i_ld_we && i_ld_func == FN_LOAD_VT) begin
            r_vt[{i_ld_row, i_ld_col}] <= i_ld_value;
        end
        r_vt_q <= r_vt[i_rd.mat_addr];
    end

    // Singular values.
    always_ff @(posedge i_clk) begin
        if (i_ld_we && i_ld_func == FN_LOAD_S) begin
            r_sv[i_ld_row] <= i_ld_value;
        end
        r_sv_q <= r_sv[i_rd.sv_addr];
    end

    // Right-hand vector.
    always_ff @(posedge i_clk) begin
        if (i_ld_we && i_ld_func == FN_LOAD_RHS) begin
            r_rhs[i_ld_row] <= i_ld_value;
        end
        r_rhs_q <= r_rhs[i_rd.vec_addr];
    end

    // Scaled coefficients written by the solve itself.
    always_ff @(posedge i_clk) begin
        if (i_cf_we) begin
            r_cf[i_cf_addr] <= i_cf_data;
        end
        r_cf_q <= r_cf[i_rd.vec_addr];
    end

    // Operand selects are registered with the read data, so they line up with it.
    always_ff @(posedge i_clk) begin
        r_sel_u  <= i_rd.use_u;
        r_sel_cf <= i_rd.use_coeff;
    end

    assign o_mat = r_sel_u ? r_u_q : r_vt_q;
    assign o_vec = r_sel_cf ? r_cf_q : r_rhs_q;
    assign o_sv  = r_sv_q;

endmodule
`default_nettype wire

### src/tsvd_mac.sv
// Shared multiply-accumulate unit with rounding and saturation of the sum.
`default_nettype none
module tsvd_mac import tsvd_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_clr,
    input  wire logic                     i_vld,
    input  wire logic signed [DATA_W-1:0] i_a,
    input  wire logic signed [DATA_W-1:0] i_b,
    output t_mac_sts                      o_sts
);

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic                     r_p_vld;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  shifted;
    logic [ACC_W-DATA_W:0]    top_bits;
    logic                     ovf;

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // Exact wide accumulator.
    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_p_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round to nearest with ties upward, then saturate to the data width.
    always_comb begin
        rnd      = r_acc + ACC_HALF;
        shifted  = rnd >>> FRAC_BITS;
        top_bits = shifted[ACC_W-1:DATA_W-1];
        ovf      = !((&top_bits) || (~|top_bits));
        o_sts.busy = r_p_vld;
        o_sts.sat  = ovf;
        if (ovf) begin
            o_sts.res = shifted[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            o_sts.res = shifted[DATA_W-1:0];
        end
    end

endmodule
`default_nettype wire

### src/tsvd_div.sv
// Bit-serial divider for t * 2^FRAC_BITS / s, rounded to nearest and saturated.
`default_nettype none
module tsvd_div import tsvd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DATA_W-1:0] i_num,
    input  wire logic [DATA_W-1:0] i_den,
    output t_div_res               o_res
);

    logic               r_busy;
    logic               r_fin;
    logic               r_done;
    logic [DIV_C_W-1:0] r_cnt;
    logic [DIV_N_W-1:0] r_dvd;
    logic [DATA_W-1:0]  r_rem;
    logic [DATA_W-1:0]  r_den;
    logic               r_neg;
    logic [DATA_W-1:0]  r_quo;
    logic               r_err;

    logic [DATA_W-1:0]  num_abs;
    logic [DATA_W-1:0]  den_abs;
    logic [DIV_N_W-1:0] dvd_init;
    logic [DATA_W:0]    rem_sh;
    logic               ge;
    logic [DATA_W:0]    rem_sub;
    logic               sat_pos;
    logic               sat_neg;
    logic [DATA_W-1:0]  q_neg;

    // Operand magnitudes and the rounded dividend |t| * 2^F + |s| / 2.
    always_comb begin
        num_abs  = i_num[DATA_W-1] ? (~i_num + 1'b1) : i_num;
        den_abs  = i_den[DATA_W-1] ? (~i_den + 1'b1) : i_den;
        dvd_init = DIV_N_W'({num_abs, {FRAC_BITS{1'b0}}}) + DIV_N_W'(den_abs >> 1);
    end

    // One restoring step per cycle.
    always_comb begin
        rem_sh  = {r_rem, r_dvd[DIV_N_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    // Saturation of the finished quotient held in r_dvd.
    always_comb begin
        sat_pos = |r_dvd[DIV_N_W-1:DATA_W-1];
        sat_neg = (|r_dvd[DIV_N_W-1:DATA_W])
               || (r_dvd[DATA_W-1] && (|r_dvd[DATA_W-2:0]));
        q_neg   = ~r_dvd[DATA_W-1:0] + 1'b1;
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                if (i_den == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= DIV_C_W'(DIV_N_W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_C_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    // Datapath of the iteration and the final result.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= dvd_init;
            r_rem <= '0;
            r_den <= den_abs;
            r_neg <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
            if (i_den == '0) begin
                r_err <= 1'b1;
                r_quo <= i_num[DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}};
            end
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            r_dvd <= {r_dvd[DIV_N_W-2:0], ge};
        end else if (r_fin) begin
            if (r_neg) begin
                r_err <= sat_neg;
                r_quo <= sat_neg ? {1'b1, {(DATA_W-1){1'b0}}} : q_neg;
            end else begin
                r_err <= sat_pos;
                r_quo <= sat_pos ? {1'b0, {(DATA_W-1){1'b1}}} : r_dvd[DATA_W-1:0];
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.err  = r_err;
    assign o_res.quo  = r_quo;

endmodule
`default_nettype wire

### src/truncated_svd_solve_top.sv
// Top level of the truncated SVD solver: sequencer, configuration and output register.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  input    | i_valid / o_stall         | i_func, i_row, i_col, i_value
//  output   | o_valid / i_stall         | o_index, o_result, o_last, o_error
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A start beat runs on one multiply-accumulate unit and one bit-serial divider: for each
// of the K coefficients a first product of inner length L1 (M or N) and a division, then
// a product of inner length K for each of the len elements of the result run. Reset is
// synchronous and active low and clears control state only. o_stall is high from a
// start beat until the last result beat is taken; a stalled result holds its payload.
`default_nettype none
module truncated_svd_solve_top import tsvd_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [FUNC_W-1:0]        i_func,
    input  wire logic [DIM_W-1:0]         i_row,
    input  wire logic [DIM_W-1:0]         i_col,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [DIM_W-1:0]              o_index,
    output logic signed [DATA_W-1:0]      o_result,
    output logic                          o_last,
    output logic                          o_error,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [CFG_W-1:0]         i_cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DOT1   = 7'b0000010,
        ST_DRAIN1 = 7'b0000100,
        ST_DIV    = 7'b0001000,
        ST_DOT2   = 7'b0010000,
        ST_DRAIN2 = 7'b0100000,
        ST_OUT    = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_rows_u, r_cols_vt, r_rank_used;
    logic              r_direction;
    logic [CNT_W-1:0]  r_m, n_m, r_n, n_n, r_k, n_k;
    logic              r_dir, n_dir;
    logic              r_phase2, n_phase2;
    logic [CNT_W-1:0]  r_outer, n_outer, r_inner, n_inner;
    logic              r_cerr, n_cerr;
    logic              r_p1_vld, n_p1_vld;
    logic [DIM_W-1:0]  r_o_index, n_o_index;
    logic [DATA_W-1:0] r_o_res, n_o_res;
    logic              r_o_last, n_o_last;
    logic              r_o_err, n_o_err;

    logic              in_acc;
    logic              out_acc;
    logic              mac_clr;
    logic              div_start;
    logic              cf_we;
    logic [CNT_W-1:0]  len_in;
    logic [CNT_W-1:0]  len_out;
    logic              pipe_empty;
    t_rd_req           rd;
    t_mac_sts          mac_sts;
    t_div_res          div_res;
    logic [DATA_W-1:0] mat_q, vec_q, sv_q;

    assign in_acc      = i_valid && !o_stall;
    assign out_acc     = o_valid && !i_stall;
    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = (r_state == ST_OUT);
    assign o_cfg_ready = 1'b1;
    assign o_index     = r_o_index;
    assign o_result    = r_o_res;
    assign o_last      = r_o_last;
    assign o_error     = r_o_err;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_u    <= CFG_W'(MAX_DIM);
            r_cols_vt   <= CFG_W'(MAX_DIM);
            r_rank_used <= CFG_W'(MAX_DIM);
            r_direction <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROWS_U:    r_rows_u    <= i_cfg_data;
                CFG_COLS_VT:   r_cols_vt   <= i_cfg_data;
                CFG_RANK_USED: r_rank_used <= i_cfg_data;
                CFG_DIRECTION: r_direction <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Inner and output lengths of the current phase.
    assign len_in     = r_phase2 ? r_k : (r_dir ? r_n : r_m);
    assign len_out    = r_dir ? r_m : r_n;
    assign pipe_empty = !r_p1_vld && !mac_sts.busy;

    // Operand addresses: the matrix is walked transposed in direction 0.
    always_comb begin
        rd.mat_addr  = r_dir ? {r_outer[DIM_W-1:0], r_inner[DIM_W-1:0]}
                             : {r_inner[DIM_W-1:0], r_outer[DIM_W-1:0]};
        rd.vec_addr  = r_inner[DIM_W-1:0];
        rd.sv_addr   = r_outer[DIM_W-1:0];
        rd.use_u     = r_phase2 ? r_dir : !r_dir;
        rd.use_coeff = r_phase2;
    end

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_m       = r_m;
        n_n       = r_n;
        n_k       = r_k;
        n_dir     = r_dir;
        n_phase2  = r_phase2;
        n_outer   = r_outer;
        n_inner   = r_inner;
        n_cerr    = r_cerr;
        n_p1_vld  = 1'b0;
        n_o_index = r_o_index;
        n_o_res   = r_o_res;
        n_o_last  = r_o_last;
        n_o_err   = r_o_err;
        mac_clr   = 1'b0;
        div_start = 1'b0;
        cf_we     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_func == FN_START) begin
                    n_m      = clamp_dim(r_rows_u);
                    n_n      = clamp_dim(r_cols_vt);
                    n_k      = clamp_rank(r_rank_used);
                    n_dir    = r_direction;
                    n_outer  = '0;
                    n_inner  = '0;
                    n_cerr   = 1'b0;
                    mac_clr  = 1'b1;
                    n_phase2 = (clamp_rank(r_rank_used) == '0);
                    n_state  = (clamp_rank(r_rank_used) == '0) ? ST_DRAIN2 : ST_DOT1;
                end
            end
            ST_DOT1, ST_DOT2: begin
                n_p1_vld = 1'b1;
                n_inner  = r_inner + 1'b1;
                if (CNT_W'(r_inner + 1'b1) == len_in) begin
                    n_state = (r_state == ST_DOT1) ? ST_DRAIN1 : ST_DRAIN2;
                end
            end
            ST_DRAIN1: begin
                if (pipe_empty) begin
                    div_start = 1'b1;
                    n_cerr    = r_cerr || mac_sts.sat;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    cf_we   = 1'b1;
                    n_cerr  = r_cerr || div_res.err;
                    mac_clr = 1'b1;
                    n_inner = '0;
                    if (CNT_W'(r_outer + 1'b1) == r_k) begin
                        n_outer  = '0;
                        n_phase2 = 1'b1;
                        n_state  = ST_DOT2;
                    end else begin
                        n_outer = r_outer + 1'b1;
                        n_state = ST_DOT1;
                    end
                end
            end
            ST_DRAIN2: begin
                if (pipe_empty) begin
                    n_o_index = r_outer[DIM_W-1:0];
                    n_o_res   = mac_sts.res;
                    n_o_last  = (CNT_W'(r_outer + 1'b1) == len_out);
                    n_o_err   = r_cerr || mac_sts.sat;
                    mac_clr   = 1'b1;
                    n_state   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    if (r_o_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_outer = r_outer + 1'b1;
                        n_inner = '0;
                        n_state = (r_k == '0) ? ST_DRAIN2 : ST_DOT2;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_p1_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= n_p1_vld;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_m       <= n_m;
        r_n       <= n_n;
        r_k       <= n_k;
        r_dir     <= n_dir;
        r_phase2  <= n_phase2;
        r_outer   <= n_outer;
        r_inner   <= n_inner;
        r_cerr    <= n_cerr;
        r_o_index <= n_o_index;
        r_o_res   <= n_o_res;
        r_o_last  <= n_o_last;
        r_o_err   <= n_o_err;
    end

    tsvd_store u_store (
        .i_clk      (i_clk),
        .i_ld_we    (in_acc),
        .i_ld_func  (i_func),
        .i_ld_row   (i_row),
        .i_ld_col   (i_col),
        .i_ld_value (i_value),
        .i_cf_we    (cf_we),
        .i_cf_addr  (r_outer[DIM_W-1:0]),
        .i_cf_data  (div_res.quo),
        .i_rd       (rd),
        .o_mat      (mat_q),
        .o_vec      (vec_q),
        .o_sv       (sv_q)
    );

    tsvd_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (mac_clr),
        .i_vld   (r_p1_vld),
        .i_a     (mat_q),
        .i_b     (vec_q),
        .o_sts   (mac_sts)
    );

    tsvd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mac_sts.res),
        .i_den   (sv_q),
        .o_res   (div_res)
    );

`ifndef SYNTH
    // A waiting result keeps the input side closed.
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result beat pending while input is open");

    // No product is in flight while the block is idle.
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_p1_vld && !mac_sts.busy))
        else $error("product in flight while idle");

    // The last result beat taken reopens the input side.
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=> !o_stall)
        else $error("input not reopened after the last result beat");

    // A coefficient is written only when the divider finishes.
    a_coeff_on_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cf_we |-> div_res.done)
        else $error("coefficient written without a quotient");
`endif

endmodule
`default_nettype wire

### dv/testbench.sv
// Self-checking testbench of the truncated SVD solver: loads, solves and result checks.
`default_nettype none
module testbench;
    import tsvd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [DIM_W-1:0]         idx;
        logic signed [DATA_W-1:0] val;
        bit                       last;
        bit                       err;
    } t_solution;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [FUNC_W-1:0]             i_func;
    logic [DIM_W-1:0]              i_row;
    logic [DIM_W-1:0]              i_col;
    logic signed [DATA_W-1:0]      i_value;
    logic                          o_valid;
    logic                          i_stall;
    logic [DIM_W-1:0]              o_index;
    logic signed [DATA_W-1:0]      o_result;
    logic                          o_last;
    logic                          o_error;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [CFG_W-1:0]              i_cfg_data;

    truncated_svd_solve_top i_dut (.*);

    // Shadow copy of the solver state.
    logic signed [DATA_W-1:0] sh_u [MAX_DIM][MAX_DIM];
    logic signed [DATA_W-1:0] sh_vt [MAX_DIM][MAX_DIM];
    logic signed [DATA_W-1:0] sh_sv [MAX_DIM];
    logic signed [DATA_W-1:0] sh_rhs [MAX_DIM];
    logic [CFG_W-1:0]         sh_rows = 5'd16;
    logic [CFG_W-1:0]         sh_cols = 5'd16;
    logic [CFG_W-1:0]         sh_rank = 5'd16;
    logic                     sh_dir = 1'b0;

    t_solution solution_q[$];
    int        n_errors = 0;
    int        n_solves = 0;
    int        n_beats = 0;
    bit        idle_on = 1'b1;
    int        hold_len = 0;

    // Clock.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Round a Q32.32 sum to Q16.16, ties upward, and saturate.
    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [80:0] s,
                                                            inout bit flag);
        logic signed [80:0] r;
        r = (s + 81'sd32768) >>> FRAC_BITS;
        if (r > 81'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (r < -81'sd2147483648) begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return r[DATA_W-1:0];
    endfunction

    // Q16.16 division, nearest with ties away from zero, saturated.
    function automatic logic signed [DATA_W-1:0] scale_coeff(input longint t, input longint s,
                                                              inout bit flag);
        longint un, ud, q;
        if (s == 0) begin
            flag = 1'b1;
            return (t >= 0) ? 32'sh7FFFFFFF : 32'sh80000000;
        end
        un = (t < 0) ? -t * 65536 : t * 65536;
        ud = (s < 0) ? -s : s;
        q = (un + ud / 2) / ud;
        if ((t < 0) != (s < 0) && t != 0) q = -q;
        if (q > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (q < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return q[DATA_W-1:0];
    endfunction

    // Expected solution vector of one start beat.
    task automatic solve_expected();
        logic signed [DATA_W-1:0] coeff [MAX_DIM];
        logic signed [80:0]       acc;
        logic [CNT_W-1:0]         m, n, k, len;
        bit                       cerr;
        bit                       e;
        t_solution                sol;
        cerr = 1'b0;
        m = clamp_dim(sh_rows);
        n = clamp_dim(sh_cols);
        k = clamp_rank(sh_rank);
        for (int i = 0; i < k; i++) begin
            acc = '0;
            if (!sh_dir) begin
                for (int j = 0; j < m; j++) acc += longint'(sh_u[j][i]) * longint'(sh_rhs[j]);
            end else begin
                for (int j = 0; j < n; j++) acc += longint'(sh_rhs[j]) * longint'(sh_vt[i][j]);
            end
            coeff[i] = round_sat(acc, cerr);
            coeff[i] = scale_coeff(longint'(coeff[i]), longint'(sh_sv[i]), cerr);
        end
        len = sh_dir ? m : n;
        for (int j = 0; j < len; j++) begin
            e = cerr;
            acc = '0;
            for (int i = 0; i < k; i++) begin
                if (!sh_dir) acc += longint'(sh_vt[i][j]) * longint'(coeff[i]);
                else acc += longint'(coeff[i]) * longint'(sh_u[j][i]);
            end
            sol.val = round_sat(acc, e);
            sol.idx = j[DIM_W-1:0];
            sol.last = (j + 1 == len);
            sol.err = e;
            solution_q.push_back(sol);
        end
        n_solves++;
    endtask

    // Track accepted input beats and configuration writes in the shadow state.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            case (i_func)
                FN_LOAD_U:   sh_u[i_row][i_col] <= i_value;
                FN_LOAD_S:   sh_sv[i_row] <= i_value;
                FN_LOAD_VT:  sh_vt[i_row][i_col] <= i_value;
                FN_LOAD_RHS: sh_rhs[i_row] <= i_value;
                FN_START:    solve_expected();
                default:     ;
            endcase
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROWS_U:    sh_rows <= i_cfg_data;
                CFG_COLS_VT:   sh_cols <= i_cfg_data;
                CFG_RANK_USED: sh_rank <= i_cfg_data;
                CFG_DIRECTION: sh_dir <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Compare each accepted result beat with the oldest expected element.
    always @(posedge i_clk) begin
        t_solution want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_beats++;
            if (solution_q.size() == 0) begin
                $display("%0t: unexpected result beat index %0d result %h", $realtime,
                         o_index, o_result);
                n_errors++;
            end else begin
                want = solution_q.pop_front();
                if (o_index !== want.idx || o_result !== want.val || o_last !== want.last ||
                        o_error !== want.err) begin
                    $display("%0t: expected idx %0d res %h last %0b err %0b, got %0d %h %0b %0b",
                             $realtime, want.idx, want.val, want.last, want.err,
                             o_index, o_result, o_last, o_error);
                    n_errors++;
                end
            end
        end
    end

    // Result side: random stall bursts, plus a long hold-off when requested.
    always @(negedge i_clk) begin
        int burst;
        if (hold_len > 0) begin
            hold_len <= hold_len - 1;
            i_stall <= 1'b1;
        end else if (burst > 0) begin
            burst--;
            i_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(0, 5);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Mix of value shapes: modest Q16.16 numbers, zero, extremes and raw bit patterns.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return ($urandom_range(0, 1)) ? 32'sh7FFFFFFF : 32'sh80000000;
            2:       return 32'sd0;
            default: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sd262144;
        endcase
    endfunction

    // Send one input beat; it may be followed by a random gap.
    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [DIM_W-1:0] r,
                             input logic [DIM_W-1:0] c, input logic signed [DATA_W-1:0] v);
        i_valid <= 1'b1;
        i_func <= fn;
        i_row <= r;
        i_col <= c;
        i_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    // Wait until every expected result is in and the block has settled.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (solution_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // Write one configuration register; the block must be idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_shape(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] n,
                             input logic [CFG_W-1:0] k, input logic d);
        wait_drained();
        write_reg(CFG_ROWS_U, m);
        write_reg(CFG_COLS_VT, n);
        write_reg(CFG_RANK_USED, k);
        write_reg(CFG_DIRECTION, {4'd0, d});
    endtask

    // Write the leading 4 x 4 corners of U and Vt and 4 entries of the S and right-hand stores;
    // solves that read anything stay inside them, and only rank-zero solves use larger dimensions.
    task automatic test_fill_stores();
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                send_item(FN_LOAD_U, DIM_W'(r), DIM_W'(c),
                          $signed($urandom_range(0, 32'h3FFFF)) - 32'sd131072);
                send_item(FN_LOAD_VT, DIM_W'(r), DIM_W'(c),
                          $signed($urandom_range(0, 32'h3FFFF)) - 32'sd131072);
            end
            send_item(FN_LOAD_S, DIM_W'(r), 0, $signed($urandom_range(32'h8000, 32'h40000)));
            send_item(FN_LOAD_RHS, DIM_W'(r), 0,
                      $signed($urandom_range(0, 32'h3FFFF)) - 32'sd131072);
        end
    endtask

    // Directed cases: both directions, saturation, zero singular value, rank zero,
    // clamped dimensions and unknown function codes.
    task automatic test_directed();
        set_shape(5'd4, 5'd4, 5'd4, 1'b0);
        send_item(FN_START, 0, 0, 0);
        set_shape(5'd4, 5'd4, 5'd4, 1'b1);
        send_item(FN_START, 4'hF, 4'hF, 32'sh7FFFFFFF);
        send_item(FN_LOAD_RHS, 0, 0, 32'sh7FFFFFFF);
        send_item(FN_LOAD_RHS, 1, 0, 32'sh80000000);
        send_item(FN_LOAD_VT, 0, 0, 32'sh80000000);
        send_item(FN_LOAD_S, 2, 4'hF, 32'sd0);
        send_item(FN_START, 0, 0, 0);
        set_shape(5'd0, 5'd31, 5'd0, 1'b0);
        send_item(FN_START, 0, 0, 0);
        set_shape(5'd31, 5'd0, 5'd0, 1'b1);
        send_item(FN_START, 0, 0, 0);
        set_shape(5'd2, 5'd3, 5'd4, 1'b1);
        send_item(3'd5, 4'hA, 4'h5, 32'sh55555555);
        send_item(3'd6, 4'h5, 4'hA, 32'shAAAAAAAA);
        send_item(3'd7, 0, 0, 0);
        send_item(FN_START, 0, 0, 0);
        set_shape(5'd1, 5'd4, 5'd1, 1'b0);
        send_item(FN_LOAD_S, 0, 0, 32'sd1);
        send_item(FN_START, 0, 0, 0);
        send_item(FN_LOAD_S, 0, 0, 32'sh80000000);
        send_item(FN_START, 0, 0, 0);
    endtask

    // Random phases: a random shape, then loads with random content and starts.
    task automatic test_random(input int phases);
        logic [FUNC_W-1:0] fn;
        for (int p = 0; p < phases; p++) begin
            set_shape(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 4)),
                      CFG_W'($urandom_range(0, 4)), 1'($urandom_range(0, 1)));
            for (int i = 0; i < 8; i++) begin
                fn = ($urandom_range(0, 4) == 0) ? FN_START : FUNC_W'($urandom_range(0, 3));
                if ($urandom_range(0, 20) == 0) fn = FUNC_W'($urandom_range(5, 7));
                send_item(fn, DIM_W'($urandom_range(0, 15)), DIM_W'($urandom_range(0, 15)),
                          pick_value());
            end
        end
    endtask

    // Hold the result side off while loads keep coming, so the input stalls.
    task automatic test_backpressure();
        set_shape(5'd4, 5'd4, 5'd3, 1'b0);
        send_item(FN_START, 0, 0, 0);
        hold_len = 600;
        for (int i = 0; i < 4; i++) send_item(FN_LOAD_RHS, DIM_W'(i), 0, pick_value());
        send_item(FN_START, 0, 0, 0);
    endtask

    // Sender pause: nothing is offered until every result has come.
    task automatic test_pause();
        send_item(FN_START, 0, 0, 0);
        wait_drained();
        send_item(FN_LOAD_RHS, 3, 0, pick_value());
        send_item(FN_START, 0, 0, 0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_func = FN_LOAD_U;
        i_row = '0;
        i_col = '0;
        i_value = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ROWS_U;
        i_cfg_data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_fill_stores();
        test_directed();
        test_random(3);
        test_backpressure();
        test_pause();
        idle_on = 1'b0;
        test_random(2);
        wait_drained();
        repeat (200) @(negedge i_clk);
        if (solution_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $realtime, solution_q.size());
            n_errors++;
        end
        $display("Ran %0d solves over random shapes and both directions, %0d result beats.",
                 n_solves, n_beats);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
src/tsvd_pkg.sv
src/tsvd_store.sv
src/tsvd_mac.sv
src/tsvd_div.sv
src/truncated_svd_solve_top.sv
dv/testbench.sv
